[rtl/fjpt_pkg.sv]
// Package for the forward jump path table: sizes, the shortcut entry type,
// the command codes and the controller states. Used by the top level of the block.
`default_nettype none
package fjpt_pkg;

  localparam int unsigned MAX_HOLES = 4096;
  localparam int unsigned BLK_LEN   = 64;

  localparam int unsigned HOLE_W = $clog2(MAX_HOLES);
  localparam int unsigned CNT_W  = $clog2(MAX_HOLES + 1);
  localparam int unsigned BLK_W  = $clog2(BLK_LEN);
  localparam int unsigned STEP_W = $clog2(BLK_LEN + 1);

  localparam logic [HOLE_W-1:0] BLK_MASK = HOLE_W'(BLK_LEN - 1);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic              in_array;
    logic [HOLE_W-1:0] target;
    logic [STEP_W-1:0] steps;
    logic [HOLE_W-1:0] last;
  } shortcut_t;

  localparam int unsigned SC_W = $bits(shortcut_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_NX,
    ST_UPD_WR,
    ST_QRY
  } state_e;

endpackage
`default_nettype wire

[rtl/fjpt_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. No dependencies.
`default_nettype none
module fjpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/forward_jump_path_table_unit.sv]
// Top level of the forward jump path table: controller, strength memory and
// shortcut memory. Depends on fjpt_pkg and fjpt_ram.
//
// A command word is taken when start_i is high and busy_o is low. An update
// (opcode 0) to a hole in range writes its strength at once and then rebuilds
// the shortcuts of the entries in use of its block (at most 64) from the top
// down, reading and then writing each entry, and keeps busy_o high until done.
// A query (opcode 1) follows one shortcut per cycle through the single read
// port of the shortcut memory and delivers its word from a register once the
// last shortcut has been read. A query at or beyond hole_count (taken as one
// when zero) answers in the next cycle with zeros. Every result word
// is shown for exactly one cycle with result_valid_o and cannot be held off.
// Queries are meaningful only after every position in use has been loaded by
// an update, and again after each change of hole_count.
`default_nettype none
module forward_jump_path_table_unit
  import fjpt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              opcode_i,
  input  wire logic [HOLE_W-1:0] hole_i,
  input  wire logic [CNT_W-1:0]  strength_i,
  output logic                   result_valid_o,
  output logic      [HOLE_W-1:0] last_hole_o,
  output logic      [CNT_W-1:0]  jump_count_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  hole_count_q;
  logic [CNT_W-1:0]  n_act;
  logic [HOLE_W-1:0] i_q, i_d;
  logic [HOLE_W-1:0] first_q, first_d;
  logic [HOLE_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0]  acc_q, acc_d;
  shortcut_t         ent_q, ent_d;
  logic              fwd_q, fwd_d;
  logic              res_valid_q, res_valid_d;
  logic [HOLE_W-1:0] res_last_q, res_last_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;

  logic              st_we, st_re;
  logic [HOLE_W-1:0] st_raddr;
  logic [CNT_W-1:0]  st_rdata;
  logic              sc_we, sc_re;
  logic [HOLE_W-1:0] sc_raddr;
  shortcut_t         sc_wdata, sc_rdata;
  logic [SC_W-1:0]   sc_rdata_raw;

  logic              accept;
  logic              hole_in_range;
  logic [HOLE_W-1:0] blk_first, blk_top, n_last;
  logic [CNT_W-1:0]  s_eff;
  logic [CNT_W:0]    nxt;
  logic [CNT_W-1:0]  acc_sum;
  logic              q_cont;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (hole_count_q == '0) begin
      n_act = CNT_W'(1);
    end else if (hole_count_q > CNT_W'(MAX_HOLES)) begin
      n_act = CNT_W'(MAX_HOLES);
    end else begin
      n_act = hole_count_q;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign accept        = start_i && !busy_o;
  assign hole_in_range = {1'b0, hole_i} < n_act;
  assign n_last        = HOLE_W'(n_act - CNT_W'(1));
  assign blk_first     = hole_i & ~BLK_MASK;
  assign blk_top       = ((blk_first | BLK_MASK) > n_last) ? n_last : (blk_first | BLK_MASK);

  assign s_eff   = (st_rdata == '0) ? CNT_W'(1) : st_rdata;
  assign nxt     = {{(CNT_W + 1 - HOLE_W){1'b0}}, i_q} + {1'b0, s_eff};
  assign sc_rdata = shortcut_t'(sc_rdata_raw);
  assign acc_sum = acc_q + {{(CNT_W - STEP_W){1'b0}}, sc_rdata.steps};
  assign q_cont  = sc_rdata.in_array && ({1'b0, sc_rdata.target} < n_act)
                   && (sc_rdata.target > cur_q);

  assign st_we = accept && (opcode_i == OP_UPDATE) && hole_in_range;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    first_d     = first_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    ent_d       = ent_q;
    fwd_d       = fwd_q;
    res_valid_d = 1'b0;
    res_last_d  = res_last_q;
    res_cnt_d   = res_cnt_q;
    st_re       = 1'b0;
    st_raddr    = i_q;
    sc_re       = 1'b0;
    sc_raddr    = hole_i;
    sc_we       = 1'b0;
    sc_wdata    = ent_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!hole_in_range) begin
            if (opcode_i == OP_QUERY) begin
              res_valid_d = 1'b1;
              res_last_d  = '0;
              res_cnt_d   = '0;
            end
          end else if (opcode_i == OP_QUERY) begin
            sc_re   = 1'b1;
            cur_d   = hole_i;
            acc_d   = '0;
            state_d = ST_QRY;
          end else begin
            first_d = blk_first;
            i_d     = blk_top;
            state_d = ST_UPD_RD;
          end
        end
      end
      ST_UPD_RD: begin
        st_re   = 1'b1;
        state_d = ST_UPD_NX;
      end
      ST_UPD_NX: begin
        fwd_d = 1'b0;
        ent_d = '{in_array: 1'b0, target: '0, steps: STEP_W'(1), last: i_q};
        if (nxt >= {1'b0, n_act}) begin
          fwd_d = 1'b0;
        end else if ((nxt >> BLK_W) != ({{(CNT_W + 1 - HOLE_W){1'b0}}, i_q} >> BLK_W)) begin
          ent_d.in_array = 1'b1;
          ent_d.target   = nxt[HOLE_W-1:0];
        end else begin
          fwd_d    = 1'b1;
          sc_re    = 1'b1;
          sc_raddr = nxt[HOLE_W-1:0];
        end
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        sc_we = 1'b1;
        if (fwd_q) begin
          sc_wdata       = sc_rdata;
          sc_wdata.steps = sc_rdata.steps + STEP_W'(1);
        end
        if (i_q == first_q) begin
          state_d = ST_IDLE;
        end else begin
          st_re    = 1'b1;
          st_raddr = i_q - HOLE_W'(1);
          i_d      = i_q - HOLE_W'(1);
          state_d  = ST_UPD_NX;
        end
      end
      ST_QRY: begin
        acc_d = acc_sum;
        if (q_cont) begin
          sc_re    = 1'b1;
          sc_raddr = sc_rdata.target;
          cur_d    = sc_rdata.target;
        end else begin
          res_valid_d = 1'b1;
          res_last_d  = sc_rdata.last;
          res_cnt_d   = acc_sum;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hole_count_q <= CNT_W'(MAX_HOLES);
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        hole_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    first_q    <= first_d;
    cur_q      <= cur_d;
    acc_q      <= acc_d;
    ent_q      <= ent_d;
    fwd_q      <= fwd_d;
    res_last_q <= res_last_d;
    res_cnt_q  <= res_cnt_d;
  end

  fjpt_ram #(
    .WIDTH(CNT_W),
    .DEPTH(MAX_HOLES)
  ) u_strength_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(hole_i),
    .wdata_i(strength_i),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  fjpt_ram #(
    .WIDTH(SC_W),
    .DEPTH(MAX_HOLES)
  ) u_shortcut_ram (
    .clk_i  (clk_i),
    .we_i   (sc_we),
    .waddr_i(i_q),
    .wdata_i(sc_wdata),
    .re_i   (sc_re),
    .raddr_i(sc_raddr),
    .rdata_o(sc_rdata_raw)
  );

  assign result_valid_o = res_valid_q;
  assign last_hole_o    = res_last_q;
  assign jump_count_o   = res_cnt_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result word shown while a command is still running");

  a_update_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_UPDATE) |=> !result_valid_o)
    else $error("update produced a result word");

  a_query_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_QUERY) |=> (busy_o || result_valid_o))
    else $error("query neither running nor answered");

  a_shortcut_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_we |-> (busy_o && !st_we))
    else $error("shortcut written outside a rebuild");

endmodule
`default_nettype wire
